[hw/rtl/lcd_nibble_expander_sequencer_top_assert.svh]
// Assertion macros for the LCD nibble expander sequencer.
`ifndef LCD_NIBBLE_EXPANDER_SEQUENCER_TOP_ASSERT_SVH
`define LCD_NIBBLE_EXPANDER_SEQUENCER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define LNES_ASSERT_IMPL(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);
`define LNES_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);
`else
`define LNES_ASSERT_IMPL(label, clk, rst, cond, expr, msg)
`define LNES_ASSERT_NEXT(label, clk, rst, cond, expr, msg)
`endif
`endif

[hw/rtl/lnes_pkg.sv]
// Types, constants and tables shared by the LCD nibble expander sequencer.
package lnes_pkg;

  typedef enum logic [1:0] {
    OP_CMD    = 2'd0,
    OP_DATA   = 2'd1,
    OP_CURSOR = 2'd2,
    OP_INIT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_NIBBLE = 2'd0,
    PH_EN_SET = 2'd1,
    PH_EN_CLR = 2'd2
  } phase_t;

  typedef struct packed {
    logic       init;
    logic       rs;
    logic       clear;
    logic [7:0] data;
  } job_t;

  localparam int IN_W  = 24;
  localparam int OUT_W = 40;

  localparam logic [7:0]  CMD_CLEAR = 8'h01;
  localparam logic [7:0]  CMD_HOME  = 8'h02;

  localparam logic [15:0] INIT_WAIT_BEFORE = 16'd50000;
  localparam logic [12:0] WAIT_NIBBLE      = 13'd0;
  localparam logic [12:0] WAIT_EN_SET      = 13'd1;
  localparam logic [12:0] WAIT_EN_CLR      = 13'd50;
  localparam logic [12:0] WAIT_CLEAR       = 13'd2000;
  localparam logic [12:0] WAIT_INIT_LONG   = 13'd4500;
  localparam logic [12:0] WAIT_INIT_SHORT  = 13'd150;

  localparam logic [3:0]  INIT_LAST_NIB = 4'd11;
  localparam logic [3:0]  BYTE_LAST_NIB = 4'd1;

  function automatic logic [7:0] line_base(input logic [1:0] row);
    logic [7:0] base;
    case (row)
      2'd0:    base = 8'h80;
      2'd1:    base = 8'hC0;
      2'd2:    base = 8'h94;
      default: base = 8'hD4;
    endcase
    return base;
  endfunction

  // Power-up nibbles: 3, 3, 3, 2, then commands 28, 0C, 06, 01.
  function automatic logic [3:0] init_nibble(input logic [3:0] idx);
    logic [3:0] nib;
    case (idx)
      4'd0, 4'd1, 4'd2: nib = 4'h3;
      4'd3:             nib = 4'h2;
      4'd4:             nib = 4'h2;
      4'd5:             nib = 4'h8;
      4'd6:             nib = 4'h0;
      4'd7:             nib = 4'hC;
      4'd8:             nib = 4'h0;
      4'd9:             nib = 4'h6;
      4'd10:            nib = 4'h0;
      4'd11:            nib = 4'h1;
      default:          nib = 4'h0;
    endcase
    return nib;
  endfunction

  function automatic logic [12:0] init_extra(input logic [3:0] idx);
    logic [12:0] extra;
    case (idx)
      4'd0, 4'd1: extra = WAIT_INIT_LONG;
      4'd2:       extra = WAIT_INIT_SHORT;
      4'd11:      extra = WAIT_CLEAR;
      default:    extra = 13'd0;
    endcase
    return extra;
  endfunction

endpackage

[hw/rtl/lnes_front.sv]
// Front end: accept requests and reduce them to byte or init jobs.
module lnes_front (
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [lnes_pkg::IN_W-1:0] s_axis_tdata,
  output logic                   push_valid,
  input  logic                   push_ready,
  output lnes_pkg::job_t         push_job
);
  import lnes_pkg::*;

  op_t        op;
  logic [7:0] value;
  logic [2:0] row;
  logic [6:0] column;
  logic [1:0] row_clamped;
  logic [7:0] cursor_addr;
  logic [7:0] cmd;

  assign op     = op_t'(s_axis_tdata[1:0]);
  assign value  = s_axis_tdata[9:2];
  assign row    = s_axis_tdata[12:10];
  assign column = s_axis_tdata[19:13];

  assign row_clamped = row[2] ? 2'd3 : row[1:0];
  assign cursor_addr = line_base(row_clamped) + {1'b0, column};
  assign cmd         = (op == OP_CURSOR) ? cursor_addr : value;

  always_comb begin
    push_job = '0;
    case (op)
      OP_CMD, OP_CURSOR: begin
        push_job.data  = cmd;
        push_job.clear = (cmd == CMD_CLEAR) || (cmd == CMD_HOME);
      end
      OP_DATA: begin
        push_job.data = value;
        push_job.rs   = 1'b1;
      end
      default: begin
        push_job.init = 1'b1;
      end
    endcase
  end

  assign push_valid    = s_axis_tvalid;
  assign s_axis_tready = push_ready;

endmodule

[hw/rtl/lnes_queue.sv]
// Short job queue between the front end and the write sequencer.
module lnes_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  lnes_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output lnes_pkg::job_t pop_job
);
  import lnes_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/lnes_back.sv]
// Write sequencer: expand each job into expander writes, three per nibble.
module lnes_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       backlight_on,
  input  logic                       job_valid,
  input  lnes_pkg::job_t             job,
  output logic                       job_pop,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [lnes_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                       m_axis_tlast
);
  import lnes_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  logic [3:0]  nib_idx;
  logic [3:0]  last_idx;
  logic [3:0]  nib;
  logic [12:0] extra;
  logic [12:0] wait_base;
  logic [15:0] wait_before;
  logic [7:0]  wr_byte;
  logic        is_last;
  logic        advance;
  logic        emit;

  assign advance  = !m_axis_tvalid || m_axis_tready;
  assign emit     = advance && job_valid;
  assign last_idx = job.init ? INIT_LAST_NIB : BYTE_LAST_NIB;
  assign is_last  = (nib_idx == last_idx) && (phase == PH_EN_CLR);
  assign job_pop  = emit && is_last;

  always_comb begin
    if (job.init) begin
      nib = init_nibble(nib_idx);
    end else begin
      nib = nib_idx[0] ? job.data[3:0] : job.data[7:4];
    end
    if (phase != PH_EN_CLR) begin
      extra = 13'd0;
    end else if (job.init) begin
      extra = init_extra(nib_idx);
    end else begin
      extra = (job.clear && nib_idx == BYTE_LAST_NIB) ? WAIT_CLEAR : 13'd0;
    end
    case (phase)
      PH_NIBBLE: begin
        wait_base  = WAIT_NIBBLE;
        phase_next = PH_EN_SET;
      end
      PH_EN_SET: begin
        wait_base  = WAIT_EN_SET;
        phase_next = PH_EN_CLR;
      end
      default: begin
        wait_base  = WAIT_EN_CLR;
        phase_next = PH_NIBBLE;
      end
    endcase
    wait_before = (job.init && nib_idx == 4'd0 && phase == PH_NIBBLE) ?
                  INIT_WAIT_BEFORE : 16'd0;
    wr_byte = {nib, backlight_on, (phase == PH_EN_SET), 1'b0, job.rs};
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= {3'b000, wait_base + extra, wait_before, wr_byte};
      m_axis_tlast <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      phase         <= PH_NIBBLE;
      nib_idx       <= '0;
    end else if (advance) begin
      m_axis_tvalid <= job_valid;
      if (job_valid) begin
        phase <= phase_next;
        if (is_last) begin
          nib_idx <= '0;
        end else if (phase == PH_EN_CLR) begin
          nib_idx <= nib_idx + 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/lcd_nibble_expander_sequencer_top.sv]
// Top level of the LCD nibble expander sequencer.
//
// Turns character-display requests into byte writes for an I2C port
// expander driving a 4-bit display. Each nibble gives three writes (nibble,
// enable set, enable clear). Command, data and set-cursor requests produce
// 6 writes, init produces 36. The write sequencer emits one write per cycle
// while the output is taken; requests are accepted whenever the job queue
// (QUEUE_DEPTH entries) has room, so the front end runs ahead of the
// sequencer. Backlight is sampled as each write is formed.
`include "lcd_nibble_expander_sequencer_top_assert.svh"
module lcd_nibble_expander_sequencer_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // op[1:0], value[9:2], row[12:10], column[19:13], zero fill
  input  logic [lnes_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // expander_byte[7:0], wait_before_us[23:8], wait_after_us[36:24], zero fill
  output logic [lnes_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                       m_axis_tlast,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_data
);
  import lnes_pkg::*;

  logic  backlight_on;
  logic  push_valid;
  logic  push_ready;
  job_t  push_job;
  logic  job_valid;
  logic  job_pop;
  job_t  job;
  logic        out_en;
  logic [15:0] out_wait_before;
  logic [12:0] out_wait_after;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      backlight_on <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      backlight_on <= cfg_data;
    end
  end

  lnes_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_job      (push_job)
  );

  lnes_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (job_valid),
    .pop_ready  (job_pop),
    .pop_job    (job)
  );

  lnes_back u_back (
    .clk           (clk),
    .rst           (rst),
    .backlight_on  (backlight_on),
    .job_valid     (job_valid),
    .job           (job),
    .job_pop       (job_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  assign out_en          = m_axis_tdata[2];
  assign out_wait_before = m_axis_tdata[23:8];
  assign out_wait_after  = m_axis_tdata[36:24];

  `LNES_ASSERT_IMPL(a_wait_before_first, clk, rst, m_axis_tvalid && out_wait_before != 16'd0, !out_en && !m_axis_tlast && out_wait_after == WAIT_NIBBLE, "wait before on a non-leading write")
  `LNES_ASSERT_IMPL(a_enable_wait, clk, rst, m_axis_tvalid && out_en, out_wait_after == WAIT_EN_SET && !m_axis_tlast, "enable write with wrong wait or last")
  `LNES_ASSERT_IMPL(a_last_en_clr, clk, rst, m_axis_tvalid && m_axis_tlast, !out_en && out_wait_after >= WAIT_EN_CLR, "last write is not an enable clear")
  `LNES_ASSERT_NEXT(a_pop_emits, clk, rst, job_pop, m_axis_tvalid && m_axis_tlast, "job retired without a last write")

endmodule
